[rtl/pcl_pkg.sv]
// Shared constants and types for the palette interval color lookup.
// Used by the controller, the datapath, the top level and the checker.
package pcl_pkg;

   localparam int MAX_ENTRIES_DEF = 128;

   localparam int CNT_W      = 8;
   localparam int IDX_W      = 7;
   localparam int BP_W       = 32;
   localparam int COLOR_W    = 24;
   localparam int CHAN_W     = 8;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 32;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic write;      // store the request's entry
      logic start;      // capture lookup value, clear search flags
      logic issue;      // read next table entry
      logic load_out;   // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic empty;      // no entries in use
      logic last_issue; // read address is the last entry in use
      logic out_busy;   // output register holds an untaken result
   } status_type;

endpackage

[rtl/palette_interval_color_lookup_core.sv]
// Palette interval color lookup: a stored table of breakpoints and colors
// that maps a signed Q16.16 value to an RGB color.
//
// Usage:
//   req_* stream carries requests. req_tuser selects the operation: a write
//   stores a breakpoint and color at entry_index, a lookup searches the
//   table. Writes give no response; each lookup gives one rsp_* item.
//   csr_* writes the entry count (saturated at MAX_ENTRIES); write it only
//   while no lookup is in flight. csr_ready is always high.
//   A write does not hold off the next request. A lookup reads the N entries
//   in use in S_SCAN, evaluates the last read in S_WAIT and loads its response
//   in S_FINISH (straight after acceptance with an empty palette); req_tready
//   stays low until the response is in the output register. The scan reads one
//   entry per cycle through the single read port of the palette memory.
//   If the receiver stalls, the response holds in the output register while
//   the next request is accepted; a further lookup waits at its end.
//   Reset clears the entry count and the handshake state; the palette
//   contents are undefined until written.
module palette_interval_color_lookup_core
   import pcl_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [6:0] entry_index, [38:7] entry_breakpoint, [62:39] entry_color,
   // [94:63] lookup_value, [95] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [30:24] match_index,
   // [31] table_ordered
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   pcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   pcl_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_data         (csr_data),
      .entry_index      (req_tdata[6:0]),
      .entry_breakpoint ($signed(req_tdata[38:7])),
      .entry_color      (req_tdata[62:39]),
      .lookup_value     ($signed(req_tdata[94:63])),
      .cmd              (cmd),
      .status           (status),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

endmodule

[rtl/pcl_ctrl.sv]
// Sequencer for the palette lookup: accepts requests, steps the scan
// and hands the result to the output register. Depends on pcl_pkg.
module pcl_ctrl
   import pcl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_op,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_WAIT   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = status.empty ? S_FINISH : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = S_WAIT;
            end
         end
         // last read data is evaluated here
         S_WAIT: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/pcl_datapath.sv]
// Palette storage, entry count, scan comparator and output register.
// Driven by pcl_ctrl through cmd_type; depends on pcl_pkg.
module pcl_datapath
   import pcl_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [CNT_W-1:0]             csr_data,
   input  logic [IDX_W-1:0]             entry_index,
   input  logic signed [BP_W-1:0]       entry_breakpoint,
   input  logic [COLOR_W-1:0]           entry_color,
   input  logic signed [BP_W-1:0]       lookup_value,
   input  cmd_type                      cmd,
   output status_type                   status,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int AW    = $clog2(MAX_ENTRIES);
   localparam int WORD_W = BP_W + COLOR_W;

   logic [WORD_W-1:0]        mem [MAX_ENTRIES];
   logic [WORD_W-1:0]        rd_data_ff;

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [AW-1:0]            rd_addr_ff;
   logic                     data_valid_ff;
   logic [AW-1:0]            data_pos_ff;

   logic signed [BP_W-1:0]   value_ff;
   logic signed [BP_W-1:0]   prev_bp_ff;
   logic [COLOR_W-1:0]       prev_color_ff;
   logic                     found_ff;
   logic [AW-1:0]            found_sel_ff;
   logic [COLOR_W-1:0]       found_color_ff;
   logic                     ordered_ff;

   logic signed [BP_W-1:0]   cur_bp;
   logic [COLOR_W-1:0]       cur_color;
   logic                     hit;

   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic [COLOR_W-1:0]       res_color;
   logic [IDX_W-1:0]         res_sel;
   logic                     mem_we;

   // Saturate the entry count at the table depth
   assign count_in = (32'(csr_data) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= count_in;
      end
   end

   // Drop writes to slots beyond the table depth
   assign mem_we = cmd.write && (32'(entry_index) < MAX_ENTRIES);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(entry_index)] <= {entry_breakpoint, entry_color};
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   assign status.empty      = (count_ff == '0);
   assign status.last_issue = (32'(rd_addr_ff) == 32'(count_ff) - 32'd1);
   assign status.out_busy   = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_valid_ff <= 1'b0;
      end else begin
         data_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_addr_ff <= '0;
      end else if (cmd.issue) begin
         rd_addr_ff <= rd_addr_ff + AW'(1);
      end
      if (cmd.issue) begin
         data_pos_ff <= rd_addr_ff;
      end
   end

   assign cur_bp    = $signed(rd_data_ff[WORD_W-1:COLOR_W]);
   assign cur_color = rd_data_ff[COLOR_W-1:0];
   assign hit       = (value_ff >= prev_bp_ff) && (value_ff < cur_bp);

   // Each returned entry closes the interval opened by the one before it
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         value_ff   <= lookup_value;
         found_ff   <= 1'b0;
         ordered_ff <= 1'b1;
      end else if (data_valid_ff) begin
         if (data_pos_ff != '0) begin
            if (prev_bp_ff >= cur_bp) begin
               ordered_ff <= 1'b0;
            end
            if (!found_ff && hit) begin
               found_ff       <= 1'b1;
               found_sel_ff   <= data_pos_ff - AW'(1);
               found_color_ff <= prev_color_ff;
            end
         end
         prev_bp_ff    <= cur_bp;
         prev_color_ff <= cur_color;
      end
   end

   always_comb begin
      if (status.empty) begin
         res_color = '0;
         res_sel   = '0;
      end else if (found_ff) begin
         res_color = found_color_ff;
         res_sel   = IDX_W'(found_sel_ff);
      end else begin
         res_color = prev_color_ff;
         res_sel   = IDX_W'(count_ff - CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {ordered_ff | status.empty, res_sel,
                         res_color[CHAN_W-1:0],
                         res_color[2*CHAN_W-1:CHAN_W],
                         res_color[3*CHAN_W-1:2*CHAN_W]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/pcl_checker.sv]
// Port-level checks for palette_interval_color_lookup_core, bound to it.
// Depends on pcl_pkg.
module pcl_checker
   import pcl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // A write request never yields a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_WRITE) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("response after write request");

   // Block new requests while a lookup runs
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_LOOKUP) |=> !req_tready)
      else $error("request accepted during lookup");

   // A new response only appears at the end of a lookup
   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response without lookup");

endmodule

bind palette_interval_color_lookup_core pcl_checker u_pcl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
